[rtl/c2p_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c2p_pkg
// Shared types, codes and constants of the chunky to planar line unit.
// ----------------------------------------------------------------------------
package c2p_pkg;

   // Register widths and reset values.
   localparam int CFG_PIXELS_W    = 10;
   localparam int CFG_PLANES_W    = 4;
   localparam int CFG_ROW_BYTES_W = 7;
   localparam int CSR_INDEX_W     = 2;
   localparam int CSR_DATA_W      = 10;

   localparam logic [CFG_PIXELS_W-1:0]    RST_LINE_PIXELS = 10'd320;
   localparam logic [CFG_PLANES_W-1:0]    RST_PLANE_COUNT = 4'd8;
   localparam logic [CFG_ROW_BYTES_W-1:0] RST_ROW_BYTES   = 7'd40;

   // Register indexes on the configuration port.
   localparam logic [CSR_INDEX_W-1:0] REG_LINE_PIXELS = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_PLANE_COUNT = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_ROW_BYTES   = 2'd2;

   // Request operations.
   localparam logic OP_PIXEL = 1'b0;
   localparam logic OP_FETCH = 1'b1;

   // Response status codes.
   localparam logic [1:0] ST_OK     = 2'd0;
   localparam logic [1:0] ST_EMPTY  = 2'd1;
   localparam logic [1:0] ST_BUSY   = 2'd2;
   localparam logic [1:0] ST_BOUNDS = 2'd3;

   // Default sizes of the line store.
   localparam int DEF_MAX_ROW_BYTES = 64;
   localparam int DEF_MAX_PLANES    = 8;

   // Column numbers carried to the cells; wide enough for 256 columns.
   localparam int COL_W = 8;

   // Control broadcast from the sequencer to every column cell.
   typedef struct packed {
      logic             clear;
      logic             shift;
      logic             write;
      logic [COL_W-1:0] col;
      logic [COL_W-1:0] last_col;
      logic [7:0]       mask;
      logic [7:0]       pixel;
   } cell_ctl_type;

   // One response as it waits in the output buffer.
   typedef struct packed {
      logic [1:0] status;
      logic [7:0] planar_byte;
      logic       last_of_line;
   } rsp_type;

endpackage

[rtl/c2p_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c2p_cell
// One byte column of the line store: one byte for each plane. Pixels OR
// their bits into the column, and during a drain the column takes its
// right neighbor's contents, the window end taking the head column's.
// ----------------------------------------------------------------------------
module c2p_cell #(
   parameter int CELL_INDEX = 0,
   parameter int MAX_PLANES = c2p_pkg::DEF_MAX_PLANES
) (
   input  logic                       clock,
   input  logic                       reset,
   input  c2p_pkg::cell_ctl_type      ctl,
   input  logic                       head_valid,
   input  logic [MAX_PLANES-1:0][7:0] head_data,
   input  logic                       next_valid,
   input  logic [MAX_PLANES-1:0][7:0] next_data,
   output logic                       cell_valid,
   output logic [MAX_PLANES-1:0][7:0] cell_data
);

   localparam logic [c2p_pkg::COL_W-1:0] MY_COL = c2p_pkg::COL_W'(CELL_INDEX);

   logic                       valid_ff;
   logic                       valid_in;
   logic [MAX_PLANES-1:0][7:0] data_ff;
   logic [MAX_PLANES-1:0][7:0] data_in;
   logic [MAX_PLANES-1:0][7:0] new_bits;
   logic                       in_window;
   logic                       at_end;

   assign in_window = (MY_COL <= ctl.last_col);
   assign at_end    = (MY_COL == ctl.last_col);

   // Spread the pixel's bits over the planes at the pixel's bit position.
   always_comb begin
      for (int p = 0; p < MAX_PLANES; p++) begin
         new_bits[p] = ctl.pixel[p] ? ctl.mask : 8'h00;
      end
   end

   // Next contents: clear, rotate within the window, or merge a pixel.
   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (ctl.clear) begin
         valid_in = 1'b0;
      end else if (ctl.shift && in_window) begin
         valid_in = at_end ? head_valid : next_valid;
         data_in  = at_end ? head_data : next_data;
      end else if (ctl.write && (ctl.col == MY_COL)) begin
         valid_in = 1'b1;
         data_in  = valid_ff ? (data_ff | new_bits) : new_bits;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   // A column that is not valid reads as cleared.
   assign cell_valid = valid_ff;
   assign cell_data  = valid_ff ? data_ff : '0;

endmodule

[rtl/c2p_out_buf.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c2p_out_buf
// Two-entry response buffer: an output register and a skid register, so a
// request is taken in the cycle the consumer stalls.
// ----------------------------------------------------------------------------
module c2p_out_buf (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  c2p_pkg::rsp_type in_data,
   output logic             out_valid,
   input  logic             out_ready,
   output c2p_pkg::rsp_type out_data
);

   logic             main_valid_ff;
   logic             main_valid_in;
   logic             skid_valid_ff;
   logic             skid_valid_in;
   c2p_pkg::rsp_type main_ff;
   c2p_pkg::rsp_type main_in;
   c2p_pkg::rsp_type skid_ff;
   c2p_pkg::rsp_type skid_in;
   logic             push;
   logic             pop;

   assign in_ready = !skid_valid_ff;
   assign push     = in_valid && in_ready;
   assign pop      = main_valid_ff && out_ready;

   // Refill the output register from the skid entry first, then from input.
   always_comb begin
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      main_in       = main_ff;
      skid_in       = skid_ff;
      if (skid_valid_ff) begin
         if (pop) begin
            main_in       = skid_ff;
            skid_valid_in = 1'b0;
         end
      end else if (push) begin
         if (!main_valid_ff || pop) begin
            main_in       = in_data;
            main_valid_in = 1'b1;
         end else begin
            skid_in       = in_data;
            skid_valid_in = 1'b1;
         end
      end else if (pop) begin
         main_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

   assign out_valid = main_valid_ff;
   assign out_data  = main_ff;

   // The skid entry is only ever filled behind a full output register.
   a_skid_behind_main: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> main_valid_ff)
      else $error("skid entry valid while output register is empty");

endmodule

[rtl/chunky_to_planar_line_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chunky_to_planar_line_unit
// Collects one line of chunky pixels into a row of byte-column cells and
// drains it as interleaved bitplane rows, plane-major, padded to row_bytes.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake             Payload
//  req_      in         req_valid/req_ready   req_operation, req_pixel
//  rsp_      out        rsp_valid/rsp_ready   rsp_status, rsp_planar_byte,
//                                             rsp_last_of_line
//  csr_      in         csr_valid/csr_ready   csr_index, csr_wdata
//
// Every request gives one response; requests are taken back to back, one per
// clock while the response buffer has room. A fetch reads the head column and
// rotates the column row one step, so a plane row drains in row_bytes fetches.
// Responses leave through a two-entry buffer; req_ready drops only when both
// entries are full. Synchronous reset clears the column valid bits at once,
// so no clearing pass follows reset. csr_ready is always high.
// ----------------------------------------------------------------------------
module chunky_to_planar_line_unit #(
   parameter int MAX_ROW_BYTES = c2p_pkg::DEF_MAX_ROW_BYTES,
   parameter int MAX_PLANES    = c2p_pkg::DEF_MAX_PLANES
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic                            req_operation,
   input  logic [7:0]                      req_pixel,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [1:0]                      rsp_status,
   output logic [7:0]                      rsp_planar_byte,
   output logic                            rsp_last_of_line,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [c2p_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [c2p_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   localparam int RB_W  = $clog2(MAX_ROW_BYTES + 1);
   localparam int CI_W  = (MAX_ROW_BYTES > 1) ? $clog2(MAX_ROW_BYTES) : 1;
   localparam int DP_W  = (MAX_PLANES > 1) ? $clog2(MAX_PLANES) : 1;
   localparam int PIX_W = c2p_pkg::CFG_PIXELS_W;
   localparam int PLN_W = c2p_pkg::CFG_PLANES_W;
   localparam int RBC_W = c2p_pkg::CFG_ROW_BYTES_W;

   // Configuration and sequencing registers.
   logic [PIX_W-1:0] line_pixels_ff;
   logic [PIX_W-1:0] line_pixels_in;
   logic [PLN_W-1:0] plane_count_ff;
   logic [PLN_W-1:0] plane_count_in;
   logic [RBC_W-1:0] row_bytes_ff;
   logic [RBC_W-1:0] row_bytes_in;
   logic [PIX_W-1:0] pos_ff;
   logic [PIX_W-1:0] pos_in;
   logic [DP_W-1:0]  drain_plane_ff;
   logic [DP_W-1:0]  drain_plane_in;
   logic [CI_W-1:0]  drain_byte_ff;
   logic [CI_W-1:0]  drain_byte_in;
   logic             draining_ff;
   logic             draining_in;
   logic             bounds_ff;
   logic             bounds_in;

   logic [PIX_W-1:0]       eff_pixels;
   logic [PLN_W-1:0]       eff_planes;
   logic [RB_W-1:0]        eff_rb;
   logic [PIX_W:0]         pos_next;
   logic                   pixel_bad;
   logic                   in_range;
   logic                   req_fire;
   logic                   csr_fire;
   logic                   buf_ready;
   c2p_pkg::cell_ctl_type  ctl;
   c2p_pkg::rsp_type       result;
   c2p_pkg::rsp_type       rsp_data;

   // Column cell row.
   logic                       cell_valid [MAX_ROW_BYTES];
   logic [MAX_PLANES-1:0][7:0] cell_data  [MAX_ROW_BYTES];

   assign csr_ready = 1'b1;
   assign csr_fire  = csr_valid && csr_ready;
   assign req_ready = buf_ready;
   assign req_fire  = req_valid && req_ready;

   // Register values outside their range act as the nearest legal value.
   always_comb begin
      eff_pixels = (line_pixels_ff == '0) ? PIX_W'(1) : line_pixels_ff;
      if (plane_count_ff == '0) begin
         eff_planes = PLN_W'(1);
      end else if (32'(plane_count_ff) > MAX_PLANES) begin
         eff_planes = PLN_W'(MAX_PLANES);
      end else begin
         eff_planes = plane_count_ff;
      end
      if (row_bytes_ff == '0) begin
         eff_rb = RB_W'(1);
      end else if (32'(row_bytes_ff) > MAX_ROW_BYTES) begin
         eff_rb = RB_W'(MAX_ROW_BYTES);
      end else begin
         eff_rb = RB_W'(row_bytes_ff);
      end
   end

   // A pixel is out of bounds if it sets a bit of a plane not in use.
   always_comb begin
      pixel_bad = 1'b0;
      for (int b = 0; b < 8; b++) begin
         if ((32'(eff_planes) <= b) && req_pixel[b]) begin
            pixel_bad = 1'b1;
         end
      end
   end

   assign in_range = (32'(pos_ff) < (32'(eff_rb) << 3));
   assign pos_next = {1'b0, pos_ff} + (PIX_W + 1)'(1);

   // Request sequencer: decides the response and the cell row control.
   always_comb begin
      line_pixels_in = line_pixels_ff;
      plane_count_in = plane_count_ff;
      row_bytes_in   = row_bytes_ff;
      pos_in         = pos_ff;
      drain_plane_in = drain_plane_ff;
      drain_byte_in  = drain_byte_ff;
      draining_in    = draining_ff;
      bounds_in      = bounds_ff;
      ctl.clear      = 1'b0;
      ctl.shift      = 1'b0;
      ctl.write      = 1'b0;
      ctl.col        = {1'b0, pos_ff[PIX_W-1:3]};
      ctl.last_col   = c2p_pkg::COL_W'(32'(eff_rb) - 32'd1);
      ctl.mask       = 8'h80 >> pos_ff[2:0];
      ctl.pixel      = req_pixel;
      result         = '0;

      if (csr_fire && (csr_index <= c2p_pkg::REG_ROW_BYTES)) begin
         case (csr_index)
            c2p_pkg::REG_LINE_PIXELS: begin
               line_pixels_in = csr_wdata[PIX_W-1:0];
            end
            c2p_pkg::REG_PLANE_COUNT: begin
               plane_count_in = csr_wdata[PLN_W-1:0];
            end
            c2p_pkg::REG_ROW_BYTES: begin
               row_bytes_in = csr_wdata[RBC_W-1:0];
            end
            default: begin
            end
         endcase
         bounds_in      = 1'b0;
         pos_in         = '0;
         drain_plane_in = '0;
         drain_byte_in  = '0;
         draining_in    = 1'b0;
         ctl.clear      = 1'b1;
      end else if (req_fire) begin
         if (bounds_ff) begin
            result.status = c2p_pkg::ST_BOUNDS;
         end else if (req_operation == c2p_pkg::OP_PIXEL) begin
            if (draining_ff) begin
               result.status = c2p_pkg::ST_BUSY;
            end else if (pixel_bad) begin
               bounds_in     = 1'b1;
               result.status = c2p_pkg::ST_BOUNDS;
            end else begin
               ctl.write = in_range;
               pos_in    = pos_next[PIX_W-1:0];
               if (pos_next >= {1'b0, eff_pixels}) begin
                  draining_in    = 1'b1;
                  drain_plane_in = '0;
                  drain_byte_in  = '0;
               end
            end
         end else begin
            if (!draining_ff) begin
               result.status = c2p_pkg::ST_EMPTY;
            end else begin
               // The head column always holds the byte being drained.
               result.planar_byte = cell_data[0][drain_plane_ff];
               ctl.shift          = 1'b1;
               if ((32'(drain_byte_ff) + 32'd1) >= 32'(eff_rb)) begin
                  drain_byte_in = '0;
                  if ((32'(drain_plane_ff) + 32'd1) >= 32'(eff_planes)) begin
                     result.last_of_line = 1'b1;
                     pos_in              = '0;
                     drain_plane_in      = '0;
                     draining_in         = 1'b0;
                     ctl.clear           = 1'b1;
                  end else begin
                     drain_plane_in = drain_plane_ff + DP_W'(1);
                  end
               end else begin
                  drain_byte_in = drain_byte_ff + CI_W'(1);
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         line_pixels_ff <= c2p_pkg::RST_LINE_PIXELS;
         plane_count_ff <= c2p_pkg::RST_PLANE_COUNT;
         row_bytes_ff   <= c2p_pkg::RST_ROW_BYTES;
         pos_ff         <= '0;
         drain_plane_ff <= '0;
         drain_byte_ff  <= '0;
         draining_ff    <= 1'b0;
         bounds_ff      <= 1'b0;
      end else begin
         line_pixels_ff <= line_pixels_in;
         plane_count_ff <= plane_count_in;
         row_bytes_ff   <= row_bytes_in;
         pos_ff         <= pos_in;
         drain_plane_ff <= drain_plane_in;
         drain_byte_ff  <= drain_byte_in;
         draining_ff    <= draining_in;
         bounds_ff      <= bounds_in;
      end
   end

   // Row of column cells; each takes its right neighbor during a drain.
   for (genvar i = 0; i < MAX_ROW_BYTES; i++) begin : g_cell
      logic                       nb_valid;
      logic [MAX_PLANES-1:0][7:0] nb_data;
      if (i == MAX_ROW_BYTES - 1) begin : g_tail
         assign nb_valid = cell_valid[0];
         assign nb_data  = cell_data[0];
      end else begin : g_body
         assign nb_valid = cell_valid[i+1];
         assign nb_data  = cell_data[i+1];
      end
      c2p_cell #(
         .CELL_INDEX (i),
         .MAX_PLANES (MAX_PLANES)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctl        (ctl),
         .head_valid (cell_valid[0]),
         .head_data  (cell_data[0]),
         .next_valid (nb_valid),
         .next_data  (nb_data),
         .cell_valid (cell_valid[i]),
         .cell_data  (cell_data[i])
      );
   end

   // Response buffer.
   c2p_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_fire),
      .in_ready  (buf_ready),
      .in_data   (result),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_data  (rsp_data)
   );

   assign rsp_status       = rsp_data.status;
   assign rsp_planar_byte  = rsp_data.planar_byte;
   assign rsp_last_of_line = rsp_data.last_of_line;

   // A drain only runs on a line that has all its pixels.
   a_drain_full_line: assert property (@(posedge clock) disable iff (reset)
      draining_ff |-> (pos_ff == eff_pixels))
      else $error("draining before the line is complete");

   // The drain counters rest at zero while a line is being filled.
   a_counters_idle: assert property (@(posedge clock) disable iff (reset)
      !draining_ff |-> ((drain_plane_ff == '0) && (drain_byte_ff == '0)))
      else $error("drain counters moved outside a drain");

   // The drain never walks past the planes in use.
   a_plane_range: assert property (@(posedge clock) disable iff (reset)
      draining_ff |-> (32'(drain_plane_ff) < 32'(eff_planes)))
      else $error("drain plane beyond plane count");

   // A bounds error is cleared only by a configuration write.
   a_bounds_sticky: assert property (@(posedge clock) disable iff (reset)
      (bounds_ff && !csr_fire) |=> bounds_ff)
      else $error("bounds error cleared without a configuration write");

   // The end-of-line mark only rides on a good fetch.
   a_last_is_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_last_of_line) |-> (rsp_status == c2p_pkg::ST_OK))
      else $error("last_of_line on a response that is not ok");

endmodule
